[hw/rtl/lcdnw_pkg.sv]
// lcdnw_pkg: types, status codes and frame byte helper for the LCD nibble writer.
// Used by lcdnw_core and i2c_lcd_nibble_writer_unit. No dependencies.
`timescale 1ns / 1ps

package lcdnw_pkg;

    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] FRAME_LEN = 3'd4;

    localparam logic [6:0] RESET_SLAVE_ADDRESS = 7'd39;
    localparam logic RESET_IGNORE_NACK = 1'b1;

    // Register indexes on the config port
    localparam logic REG_SLAVE_ADDRESS = 1'b0;
    localparam logic REG_IGNORE_NACK = 1'b1;

    // Transaction kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_STATUS = 1'b1;

    // I2C controller status codes
    localparam logic [7:0] ST_START_SENT = 8'h08;
    localparam logic [7:0] ST_ADDR_ACK = 8'h18;
    localparam logic [7:0] ST_ADDR_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST = 8'h38;

    // Backpack control bits in the low nibble
    localparam logic [3:0] LCD_BACKLIGHT = 4'h8;
    localparam logic [3:0] LCD_ENABLE = 4'h4;
    localparam logic [3:0] LCD_RS = 4'h1;

    typedef struct packed {
        logic [7:0] status_code;
        logic       register_select;
        logic [7:0] char_byte;
        logic       func;
    } item_t;

    typedef struct packed {
        logic [6:0] slave_address;
        logic       ignore_nack;
    } cfg_t;

    typedef struct packed {
        logic             address_nack;
        logic [CNT_W-1:0] sent_count;
        logic             done_res;
        logic             set_stop;
        logic             clear_stop;
        logic             clear_interrupt;
        logic             clear_start;
        logic [7:0]       data_byte;
        logic             load_data;
        logic             set_start;
        logic             accepted;
    } result_t;

    // Frame byte idx: 0 high nibble E=1, 1 high nibble E=0, 2 low nibble E=1, 3 low nibble E=0
    function automatic logic [7:0] frame_byte(input logic [7:0] ch, input logic rs,
                                              input logic [1:0] idx);
        logic [3:0] nib;
        logic [3:0] ctl;
        nib = idx[1] ? ch[3:0] : ch[7:4];
        ctl = LCD_BACKLIGHT | (idx[0] ? 4'h0 : LCD_ENABLE) | (rs ? LCD_RS : 4'h0);
        return {nib, ctl};
    endfunction

endpackage

[hw/rtl/lcdnw_core.sv]
// lcdnw_core: sequencer state (busy, byte count, latched character) and the
// per-transaction decision logic. Depends on lcdnw_pkg.
`timescale 1ns / 1ps

module lcdnw_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  lcdnw_pkg::item_t   item,
    input  lcdnw_pkg::cfg_t    cfg,
    output lcdnw_pkg::result_t result
);
    import lcdnw_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       char_reg, char_next;
    logic             rs_reg, rs_next;

    logic [7:0]       status_eff;
    logic [CNT_W-1:0] count_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (advance) begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
        if (advance) begin
            char_reg <= char_next;
            rs_reg   <= rs_next;
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        char_next  = char_reg;
        rs_next    = rs_reg;
        result     = '0;
        status_eff = (item.status_code == ST_DATA_NACK && cfg.ignore_nack) ?
                     ST_DATA_ACK : item.status_code;
        count_inc  = (count_reg < FRAME_LEN) ? count_reg + 3'd1 : count_reg;

        if (item.func == FUNC_WRITE) begin
            if (!busy_reg) begin
                char_next        = item.char_byte;
                rs_next          = item.register_select;
                busy_next        = 1'b1;
                count_next       = '0;
                result.accepted  = 1'b1;
                result.set_start = 1'b1;
            end
        end else begin
            unique case (status_eff)
                ST_START_SENT: begin
                    result.load_data       = 1'b1;
                    result.data_byte       = {cfg.slave_address, 1'b0};
                    result.clear_start     = 1'b1;
                    result.clear_interrupt = 1'b1;
                end
                ST_ADDR_ACK: begin
                    result.clear_start     = 1'b1;
                    result.clear_interrupt = 1'b1;
                    if (count_reg < FRAME_LEN) begin
                        result.load_data  = 1'b1;
                        result.data_byte  = frame_byte(char_reg, rs_reg, 2'd0);
                        result.clear_stop = 1'b1;
                    end else begin
                        result.set_stop = 1'b1;
                        result.done_res = 1'b1;
                        busy_next       = 1'b0;
                    end
                end
                ST_ADDR_NACK: begin
                    result.clear_start     = 1'b1;
                    result.clear_interrupt = 1'b1;
                    result.set_stop        = 1'b1;
                    result.done_res        = 1'b1;
                    result.address_nack    = 1'b1;
                    busy_next              = 1'b0;
                    count_next             = '0;
                end
                ST_DATA_ACK: begin
                    count_next             = count_inc;
                    result.clear_start     = 1'b1;
                    result.clear_interrupt = 1'b1;
                    if (count_inc < FRAME_LEN) begin
                        result.load_data  = 1'b1;
                        result.data_byte  = frame_byte(char_reg, rs_reg, count_inc[1:0]);
                        result.clear_stop = 1'b1;
                    end else begin
                        result.set_stop = 1'b1;
                        result.done_res = 1'b1;
                        busy_next       = 1'b0;
                    end
                end
                ST_DATA_NACK: begin
                    result.clear_start     = 1'b1;
                    result.clear_interrupt = 1'b1;
                    result.set_stop        = 1'b1;
                    result.done_res        = 1'b1;
                    busy_next              = 1'b0;
                end
                ST_ARB_LOST: begin
                    result.clear_start     = 1'b1;
                    result.clear_interrupt = 1'b1;
                    result.clear_stop      = 1'b1;
                    result.done_res        = 1'b1;
                    busy_next              = 1'b0;
                end
                default: begin
                end
            endcase
        end
        result.sent_count = count_next;
    end

endmodule

[hw/rtl/i2c_lcd_nibble_writer_unit.sv]
// i2c_lcd_nibble_writer_unit: top level with APB config registers, input
// stage and output register around lcdnw_core. Depends on lcdnw_pkg, lcdnw_core.
//
//  channel  | direction | tdata / tuser
//  s_       | in        | tdata: char_byte, register_select, status_code; tuser: func
//  m_       | out       | tdata: accepted .. address_nack (20 bits, zero padded)
//  APB      | in        | 0x0 slave_address, 0x4 ignore_nack
//
// One transaction per cycle sustained while m_ is not stalled; each passes the input stage, then the result register.
// The decision for a transaction is made as it leaves the input stage, against the
// sequencer state left by the transaction before it.
// Reset (aresetn low, synchronous) empties both stages and idles the sequencer.
// A stall on m_ holds the result; s_tready drops while both stages are full and m_tready is low.
`timescale 1ns / 1ps

module i2c_lcd_nibble_writer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_byte, [8] register_select, [16:9] status_code, [23:17] zero
    input  logic [23:0] s_tdata,
    // [0] func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [1] set_start, [2] load_data, [10:3] data_byte, [11] clear_start,
    // [12] clear_interrupt, [13] clear_stop, [14] set_stop, [15] done_res,
    // [18:16] sent_count, [19] address_nack, [23:20] zero
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdnw_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t result;
    logic    advance;
    logic    cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address <= RESET_SLAVE_ADDRESS;
            cfg_reg.ignore_nack   <= RESET_IGNORE_NACK;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SLAVE_ADDRESS: cfg_reg.slave_address <= pwdata[6:0];
                REG_IGNORE_NACK:   cfg_reg.ignore_nack   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_SLAVE_ADDRESS: prdata = {25'd0, cfg_reg.slave_address};
            REG_IGNORE_NACK:   prdata = {31'd0, cfg_reg.ignore_nack};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            item_reg.func            <= s_tuser;
            item_reg.char_byte       <= s_tdata[7:0];
            item_reg.register_select <= s_tdata[8];
            item_reg.status_code     <= s_tdata[16:9];
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    lcdnw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

endmodule

[hw/rtl/lcdnw_checker.sv]
// lcdnw_checker: port-level assertions for i2c_lcd_nibble_writer_unit, with bind.
// Depends on i2c_lcd_nibble_writer_unit ports only.
`timescale 1ns / 1ps

module lcdnw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_accept_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[15]))
        else $error("request accepted and transfer done in one transaction");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'd0)
        else $error("data_byte nonzero without load_data");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:16] <= 3'd4)
        else $error("sent_count out of range");

endmodule

bind i2c_lcd_nibble_writer_unit lcdnw_checker u_lcdnw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/i2c_lcd_nibble_writer_unit_tb.sv]
// i2c_lcd_nibble_writer_unit_tb: self-checking bench for the LCD nibble writer sequencer.
// Drives write requests and bus status events on s_, checks every m_ result against
// an in-bench sequencer model, and steps the APB registers between phases. Needs lcdnw_pkg.
`timescale 1ns / 1ps

module i2c_lcd_nibble_writer_unit_tb;

    import lcdnw_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_PER_PHASE = 205;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_lcd_nibble_writer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // sequencer model state and register copies
    logic       seq_busy = 1'b0;
    logic [2:0] seq_count = '0;
    logic [7:0] seq_frame [4];
    logic [6:0] cfg_addr = RESET_SLAVE_ADDRESS;
    logic       cfg_ignore_nack = RESET_IGNORE_NACK;

    item_t   lcd_requests_q [$];
    result_t bus_actions_q [$];

    int n_in = 0;
    int n_out = 0;
    int n_mismatch = 0;
    int n_refused = 0;
    int n_finished = 0;
    int n_settings = 1;
    int n_cycles = 0;

    item_t       cur_req;
    logic        s_fire;
    int unsigned idle_s = 0;
    int unsigned calm_s = 0;
    int unsigned stall_m = 0;
    int unsigned calm_m = 0;
    result_t     got_res;
    result_t     want_res;

    function automatic result_t step_sequencer(item_t it);
        result_t    r;
        logic [7:0] st;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [3:0] ctl;
        r = '0;
        if (it.func == FUNC_WRITE) begin
            if (!seq_busy) begin
                hi = {it.char_byte[7:4], 4'h0};
                lo = {it.char_byte[3:0], 4'h0};
                ctl = LCD_BACKLIGHT | (it.register_select ? LCD_RS : 4'h0);
                seq_frame[0] = hi | {4'h0, ctl | LCD_ENABLE};
                seq_frame[1] = hi | {4'h0, ctl};
                seq_frame[2] = lo | {4'h0, ctl | LCD_ENABLE};
                seq_frame[3] = lo | {4'h0, ctl};
                seq_busy = 1'b1;
                seq_count = '0;
                r.accepted = 1'b1;
                r.set_start = 1'b1;
            end else begin
                n_refused++;
            end
        end else begin
            st = it.status_code;
            if (st == ST_DATA_NACK && cfg_ignore_nack)
                st = ST_DATA_ACK;
            if (st == ST_DATA_ACK && seq_count < FRAME_LEN)
                seq_count = seq_count + 3'd1;
            case (st)
                ST_START_SENT: begin
                    r.load_data = 1'b1;
                    r.data_byte = {cfg_addr, 1'b0};
                    r.clear_start = 1'b1;
                    r.clear_interrupt = 1'b1;
                end
                ST_ADDR_ACK, ST_DATA_ACK: begin
                    if (seq_count < FRAME_LEN) begin
                        r.load_data = 1'b1;
                        r.data_byte = (st == ST_ADDR_ACK) ? seq_frame[0]
                                                          : seq_frame[seq_count[1:0]];
                        r.clear_start = 1'b1;
                        r.clear_interrupt = 1'b1;
                        r.clear_stop = 1'b1;
                    end else begin
                        r.clear_start = 1'b1;
                        r.clear_interrupt = 1'b1;
                        r.set_stop = 1'b1;
                        r.done_res = 1'b1;
                        seq_busy = 1'b0;
                    end
                end
                ST_ADDR_NACK, ST_DATA_NACK: begin
                    r.clear_start = 1'b1;
                    r.clear_interrupt = 1'b1;
                    r.set_stop = 1'b1;
                    r.done_res = 1'b1;
                    seq_busy = 1'b0;
                    if (st == ST_ADDR_NACK) begin
                        seq_count = '0;
                        r.address_nack = 1'b1;
                    end
                end
                ST_ARB_LOST: begin
                    r.clear_start = 1'b1;
                    r.clear_interrupt = 1'b1;
                    r.clear_stop = 1'b1;
                    r.done_res = 1'b1;
                    seq_busy = 1'b0;
                end
                default: ;
            endcase
        end
        r.sent_count = seq_count;
        if (r.done_res)
            n_finished++;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic item_t mk_write(input logic [7:0] ch, input logic rs);
        item_t x;
        x.func = FUNC_WRITE;
        x.char_byte = ch;
        x.register_select = rs;
        x.status_code = 8'($urandom);
        return x;
    endfunction

    function automatic item_t mk_event(input logic [7:0] code);
        item_t x;
        x.func = FUNC_STATUS;
        x.char_byte = 8'($urandom);
        x.register_select = 1'($urandom);
        x.status_code = code;
        return x;
    endfunction

    // one well-formed transfer with random content and occasional faults; returns items queued
    function automatic int add_transfer();
        int base;
        int roll;
        int k;
        base = lcd_requests_q.size();
        lcd_requests_q.push_back(mk_write(8'($urandom), 1'($urandom)));
        if ($urandom_range(0, 9) == 0)
            lcd_requests_q.push_back(mk_write(8'($urandom), 1'($urandom)));
        if ($urandom_range(0, 14) == 0)
            lcd_requests_q.push_back(mk_event(8'($urandom)));
        lcd_requests_q.push_back(mk_event(ST_START_SENT));
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            lcd_requests_q.push_back(mk_event(ST_ADDR_NACK));
        end else if (roll < 12) begin
            lcd_requests_q.push_back(mk_event(ST_ARB_LOST));
        end else begin
            lcd_requests_q.push_back(mk_event(ST_ADDR_ACK));
            for (k = 0; k < 4; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    lcd_requests_q.push_back(mk_event(ST_DATA_NACK));
                    if (!cfg_ignore_nack)
                        break;
                end else if (roll < 11) begin
                    lcd_requests_q.push_back(mk_event(ST_ARB_LOST));
                    break;
                end else if (roll < 16) begin
                    lcd_requests_q.push_back(mk_event(8'($urandom)));
                    lcd_requests_q.push_back(mk_event(ST_DATA_ACK));
                end else begin
                    lcd_requests_q.push_back(mk_event(ST_DATA_ACK));
                end
            end
            if ($urandom_range(0, 19) == 0)
                lcd_requests_q.push_back(mk_event(ST_ADDR_ACK));
        end
        return lcd_requests_q.size() - base;
    endfunction

    function automatic void check_field(string nm, int unsigned want, int unsigned got);
        if (want != got) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                         n_out, nm, want, got);
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            s_fire = s_tvalid && s_tready;
            if (s_fire) begin
                bus_actions_q.push_back(step_sequencer(cur_req));
                n_in++;
                if (calm_s > 0) begin
                    calm_s--;
                    idle_s = 0;
                end else begin
                    idle_s = pick_gap();
                    if ($urandom_range(0, 39) == 0)
                        calm_s = $urandom_range(20, 80);
                end
            end
            if (!s_tvalid || s_fire) begin
                if (idle_s > 0) begin
                    idle_s--;
                    s_tvalid <= 1'b0;
                end else if (lcd_requests_q.size() > 0) begin
                    cur_req = lcd_requests_q.pop_front();
                    s_tdata <= {7'd0, cur_req.status_code, cur_req.register_select,
                                cur_req.char_byte};
                    s_tuser <= cur_req.func;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_res = result_t'(m_tdata[19:0]);
                if (bus_actions_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result %0d: m_tdata 0x%06h", n_out, m_tdata);
                end else begin
                    want_res = bus_actions_q.pop_front();
                    check_field("accepted", want_res.accepted, got_res.accepted);
                    check_field("set_start", want_res.set_start, got_res.set_start);
                    check_field("load_data", want_res.load_data, got_res.load_data);
                    check_field("data_byte", want_res.data_byte, got_res.data_byte);
                    check_field("clear_start", want_res.clear_start, got_res.clear_start);
                    check_field("clear_interrupt", want_res.clear_interrupt,
                                got_res.clear_interrupt);
                    check_field("clear_stop", want_res.clear_stop, got_res.clear_stop);
                    check_field("set_stop", want_res.set_stop, got_res.set_stop);
                    check_field("done_res", want_res.done_res, got_res.done_res);
                    check_field("sent_count", want_res.sent_count, got_res.sent_count);
                    check_field("address_nack", want_res.address_nack, got_res.address_nack);
                    check_field("padding", 0, m_tdata[23:20]);
                end
                n_out++;
            end
            if (stall_m > 0) begin
                stall_m--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (calm_m > 0)
                    calm_m--;
                else if ($urandom_range(0, 3) == 0)
                    stall_m = pick_gap();
                else if ($urandom_range(0, 149) == 0)
                    calm_m = $urandom_range(30, 100);
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen", n_cycles, n_out, n_in);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SLAVE_ADDRESS)
            cfg_addr = val[6:0];
        else
            cfg_ignore_nack = val[0];
    endtask

    task automatic set_config(input logic [6:0] addr, input logic ign);
        write_reg(REG_SLAVE_ADDRESS, {25'd0, addr});
        write_reg(REG_IGNORE_NACK, {31'd0, ign});
        n_settings++;
    endtask

    // drain: nothing queued, nothing in flight, then a wait for the pipeline
    // sampled on the falling edge so the driver's updates at the rising edge have settled
    task automatic wait_idle();
        while (!(lcd_requests_q.size() == 0 && !s_tvalid && n_in == n_out))
            @(negedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic fill_random(input int target);
        int useful;
        useful = 0;
        while (useful < target) begin
            if ($urandom_range(0, 9) == 0) begin
                lcd_requests_q.push_back(item_t'(18'($urandom_range(0, 18'h3FFFF))));
                useful++;
            end else begin
                useful += add_transfer();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // full transfer, empty-frame stop, saturation, refusal, NACK paths, arbitration loss
        lcd_requests_q.push_back(mk_write(8'h00, 1'b0));
        lcd_requests_q.push_back(mk_event(ST_START_SENT));
        lcd_requests_q.push_back(mk_event(ST_ADDR_ACK));
        repeat (4) lcd_requests_q.push_back(mk_event(ST_DATA_ACK));
        lcd_requests_q.push_back(mk_event(ST_ADDR_ACK));
        lcd_requests_q.push_back(mk_event(ST_DATA_ACK));
        lcd_requests_q.push_back(mk_write(8'hFF, 1'b1));
        lcd_requests_q.push_back(mk_write(8'h5A, 1'b0));
        lcd_requests_q.push_back(mk_event(ST_START_SENT));
        lcd_requests_q.push_back(mk_event(ST_ADDR_NACK));
        lcd_requests_q.push_back(mk_write(8'hA5, 1'b1));
        lcd_requests_q.push_back(mk_event(ST_START_SENT));
        lcd_requests_q.push_back(mk_event(ST_ADDR_ACK));
        lcd_requests_q.push_back(mk_event(ST_DATA_NACK));
        lcd_requests_q.push_back(mk_event(ST_ARB_LOST));
        lcd_requests_q.push_back(mk_event(8'h00));
        lcd_requests_q.push_back(mk_event(8'hFF));
        lcd_requests_q.push_back(mk_event(ST_DATA_ACK));
        wait_idle();

        set_config(7'd127, 1'b0);
        lcd_requests_q.push_back(mk_write(8'h3C, 1'b0));
        lcd_requests_q.push_back(mk_event(ST_START_SENT));
        lcd_requests_q.push_back(mk_event(ST_ADDR_ACK));
        lcd_requests_q.push_back(mk_event(ST_DATA_NACK));
        lcd_requests_q.push_back(mk_event(ST_START_SENT));
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(7'd0, 1'b1);
                1: set_config(7'd127, 1'b0);
                4: set_config(RESET_SLAVE_ADDRESS, RESET_IGNORE_NACK);
                default: set_config(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            endcase
            fill_random(RAND_PER_PHASE);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        $display("covered %0d transactions under %0d register settings, %0d results checked",
                 n_in, n_settings, n_out);
        $display("%0d transfers finished, %0d busy requests refused", n_finished, n_refused);
        if (n_mismatch == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
